/* hdl/mrwt_pkg.sv */
// Shared types and constants for the Miller-Rabin witness test unit.
package mrwt_pkg;
  localparam int unsigned NumWidth = 32;
  localparam int unsigned CntWidth = $clog2(NumWidth + 1);
  localparam int unsigned BitWidth = $clog2(NumWidth);

  typedef logic [NumWidth-1:0] num_t;

  typedef enum logic [1:0] {
    VERDICT_COMPOSITE = 2'd0,
    VERDICT_PRIME     = 2'd1,
    VERDICT_RANGE     = 2'd2
  } verdict_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_SQR,
    ST_SQR_WAIT,
    ST_MUL,
    ST_MUL_WAIT,
    ST_CHECK,
    ST_LOOP,
    ST_LOOP_WAIT,
    ST_DONE
  } state_e;

  // Request to the serial modular multiplier.
  typedef struct packed {
    logic start;
    num_t x;
    num_t y;
    num_t m;
  } mm_req_t;

  typedef struct packed {
    logic done;
    num_t p;
  } mm_rsp_t;
endpackage

/* hdl/mrwt_modmul.sv */
// Bit-serial interleaved modular multiplier: p = x * y mod m, one bit of y per cycle.
module mrwt_modmul (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mrwt_pkg::mm_req_t req_i,
  output mrwt_pkg::mm_rsp_t rsp_o
);
  import mrwt_pkg::*;

  logic             busy_q, busy_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  num_t             x_q, x_d, y_q, y_d, m_q, m_d, acc_q, acc_d;
  logic             done_q, done_d;

  // acc < m, so 2*acc + x needs two extra bits; two conditional subtracts.
  logic [NumWidth+1:0] dbl, add1, sub1, sub2;

  always_comb begin
    dbl  = {1'b0, acc_q, 1'b0};
    add1 = dbl + (y_q[NumWidth-1] ? {2'b00, x_q} : '0);
    sub1 = (add1 >= {2'b00, m_q}) ? add1 - {2'b00, m_q} : add1;
    sub2 = (sub1 >= {2'b00, m_q}) ? sub1 - {2'b00, m_q} : sub1;
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    m_d    = m_q;
    acc_d  = acc_q;
    done_d = 1'b0;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CntWidth'(NumWidth);
      x_d    = req_i.x;
      y_d    = req_i.y;
      m_d    = req_i.m;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = sub2[NumWidth-1:0];
      y_d   = {y_q[NumWidth-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    m_q   <= m_d;
    acc_q <= acc_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.p    = acc_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("modmul done without work");
  a_no_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("modmul done while busy");
  a_acc_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> acc_q < m_q) else $error("modmul accumulator not reduced");
endmodule

/* hdl/miller_rabin_witness_test_unit.sv */
// Top level: Miller-Rabin single-round witness test, sequencer plus serial multiplier.
// Flow: trivial and out-of-range cases pass from accept through the split state to done, a
//   candidate of 3 after one trailing zero is stripped; a full test runs up to 2*NumWidth-1
//   multiplies on the bit-serial multiplier, a check step per exponent bit position and a split step per zero.
// Throughput: one test at a time; busy is high from accept until the cycle before the strobe.
// Reset: asynchronous active low, returns the sequencer to idle; no result is pending.
// Results are shown for one cycle on verdict_o with valid_o and cannot be stalled.
module miller_rabin_witness_test_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] candidate_i,
  input  logic [31:0] witness_i,
  output logic        valid_o,
  output logic [1:0]  verdict_o
);
  import mrwt_pkg::*;

  state_e state_q, state_d;
  num_t   n_q, n_d, nm1_q, nm1_d, a_q, a_d, d_q, d_d, x_q, x_d;
  logic [CntWidth-1:0] s_q, s_d, bit_q, bit_d;
  verdict_e verd_q, verd_d;
  logic   vld_q, vld_d;
  mm_req_t req;
  mm_rsp_t rsp;

  num_t n_in, a_in;
  assign n_in = candidate_i[NumWidth-1:0];
  assign a_in = witness_i[NumWidth-1:0];

  mrwt_modmul u_mm (.clk_i, .rst_ni, .req_i(req), .rsp_o(rsp));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (start) state_d = ST_SPLIT;
      ST_SPLIT: begin
        if (verd_q != VERDICT_PRIME || (d_q[0] && n_q <= num_t'(3))) state_d = ST_DONE;
        else if (d_q[0]) state_d = ST_SQR;
      end
      ST_SQR:       state_d = ST_SQR_WAIT;
      ST_SQR_WAIT:  if (rsp.done) state_d = d_q[bit_q[BitWidth-1:0]] ? ST_MUL : ST_CHECK;
      ST_MUL:       state_d = ST_MUL_WAIT;
      ST_MUL_WAIT:  if (rsp.done) state_d = ST_CHECK;
      ST_CHECK: begin
        if (bit_q != '0) state_d = ST_SQR;
        else if (x_q == num_t'(1) || x_q == nm1_q || s_q <= CntWidth'(1)) state_d = ST_DONE;
        else state_d = ST_LOOP;
      end
      ST_LOOP:      state_d = ST_LOOP_WAIT;
      ST_LOOP_WAIT: if (rsp.done) begin
        if (rsp.p == nm1_q || rsp.p == num_t'(1) || s_q <= CntWidth'(2)) state_d = ST_DONE;
        else state_d = ST_LOOP;
      end
      ST_DONE:      state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    n_d = n_q; nm1_d = nm1_q; a_d = a_q; d_d = d_q; x_d = x_q;
    s_d = s_q; bit_d = bit_q; verd_d = verd_q; vld_d = 1'b0;
    req = '{start: 1'b0, x: x_q, y: x_q, m: n_q};
    case (state_q)
      ST_IDLE: if (start) begin
        n_d   = n_in;
        a_d   = a_in;
        nm1_d = n_in - 1'b1;
        d_d   = n_in - 1'b1;
        s_d   = '0;
        if (n_in == num_t'(2) || n_in == num_t'(3)) verd_d = VERDICT_PRIME;
        else if (n_in <= num_t'(1) || !n_in[0]) verd_d = VERDICT_COMPOSITE;
        else if (a_in < num_t'(2) || a_in > n_in - num_t'(2)) verd_d = VERDICT_RANGE;
        else verd_d = VERDICT_PRIME;
      end
      ST_SPLIT: begin
        // one trailing zero stripped per cycle; then start the exponent scan at bit NumWidth-1
        if (!d_q[0]) begin
          d_d = d_q >> 1;
          s_d = s_q + 1'b1;
        end else begin
          x_d   = num_t'(1);
          bit_d = CntWidth'(NumWidth - 1);
        end
      end
      ST_SQR: req = '{start: 1'b1, x: x_q, y: x_q, m: n_q};
      ST_SQR_WAIT: if (rsp.done) x_d = rsp.p;
      ST_MUL: req = '{start: 1'b1, x: x_q, y: a_q, m: n_q};
      ST_MUL_WAIT: if (rsp.done) x_d = rsp.p;
      ST_CHECK: begin
        if (bit_q != '0) bit_d = bit_q - 1'b1;
        else if (x_q == num_t'(1) || x_q == nm1_q) verd_d = VERDICT_PRIME;
        else verd_d = VERDICT_COMPOSITE;
        if (bit_q == '0 && !(x_q == num_t'(1) || x_q == nm1_q) && s_q > CntWidth'(1))
          s_d = s_q;
      end
      ST_LOOP: req = '{start: 1'b1, x: x_q, y: x_q, m: n_q};
      ST_LOOP_WAIT: if (rsp.done) begin
        x_d = rsp.p;
        s_d = s_q - 1'b1;
        verd_d = (rsp.p == nm1_q) ? VERDICT_PRIME : VERDICT_COMPOSITE;
      end
      ST_DONE: vld_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vld_q   <= 1'b0;
      verd_q  <= VERDICT_COMPOSITE;
      s_q     <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
      verd_q  <= verd_d;
      s_q     <= s_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; nm1_q <= nm1_d; a_q <= a_d; d_q <= d_d; x_q <= x_d;
  end

  assign busy      = (state_q != ST_IDLE);
  assign valid_o   = vld_q;
  assign verdict_o = verd_q;

  a_valid_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(state_q == ST_DONE)) else $error("result without done");
  a_idle_after_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy) else $error("busy on result beat");
  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> verdict_o != 2'd3) else $error("bad verdict");
endmodule

/* tb/miller_rabin_witness_test_unit_tb.sv */
// Self-checking testbench for the Miller-Rabin single-round witness test unit.
module miller_rabin_witness_test_unit_tb;
  import mrwt_pkg::*;

  localparam int unsigned LimitCycles = 3_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [31:0] candidate_i;
  logic [31:0] witness_i;
  logic        valid_o;
  logic [1:0]  verdict_o;

  verdict_e    verdict_q[$];
  int unsigned err_cnt;
  int unsigned beat_cnt;
  int unsigned result_cnt;
  int unsigned cycle_cnt;
  int unsigned idle_pct;

  miller_rabin_witness_test_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .candidate_i (candidate_i),
    .witness_i   (witness_i),
    .valid_o     (valid_o),
    .verdict_o   (verdict_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [63:0] mod_mul(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    return (x * y) % m;
  endfunction

  // One Miller-Rabin round, including the repeated squaring phase.
  function automatic verdict_e mr_round(num_t n_in, num_t a_in);
    logic [63:0] n;
    logic [63:0] a;
    logic [63:0] d;
    logic [63:0] x;
    logic [63:0] b;
    logic [63:0] e;
    int unsigned s;
    n = 64'(n_in);
    a = 64'(a_in);
    s = 0;
    if (n == 2 || n == 3) return VERDICT_PRIME;
    if (n <= 1 || !n[0]) return VERDICT_COMPOSITE;
    if (a < 2 || a > n - 2) return VERDICT_RANGE;
    d = n - 1;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    x = 1;
    b = a % n;
    e = d;
    while (e != 0) begin
      if (e[0]) x = mod_mul(x, b, n);
      b = mod_mul(b, b, n);
      e = e >> 1;
    end
    if (x == 1 || x == n - 1) return VERDICT_PRIME;
    for (int unsigned i = 1; i < s; i++) begin
      x = mod_mul(x, x, n);
      if (x == n - 1) return VERDICT_PRIME;
      if (x == 1) return VERDICT_COMPOSITE;
    end
    return VERDICT_COMPOSITE;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic expect_verdict(verdict_e v);
    verdict_q = {verdict_q, v};
  endtask

  // Sends one test beat, honoring the current idle percentage.
  task automatic send_test(logic [31:0] n, logic [31:0] a);
    while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    start       <= 1'b1;
    candidate_i <= n;
    witness_i   <= a;
    expect_verdict(mr_round(num_t'(n), num_t'(a)));
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    start <= 1'b0;
    // the unit is busy on the next cycle anyway
    @(posedge clk_i);
    beat_cnt++;
  endtask

  task automatic wait_drained();
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_odd(int unsigned lo, int unsigned hi);
    return $urandom_range(hi, lo) | 32'd1;
  endfunction

  // Random witness in 2..n-2 for odd n of 5 or more.
  function automatic logic [31:0] rand_witness(logic [31:0] n);
    return $urandom_range(n - 2, 2);
  endfunction

  task automatic test_trivial();
    send_test(32'd0, 32'd7);
    send_test(32'd1, 32'hFFFF_FFFF);
    send_test(32'd2, 32'd0);
    send_test(32'd3, 32'hFFFF_FFFF);
    send_test(32'd4, 32'd2);
    send_test(32'hFFFF_FFFE, 32'd5);
  endtask

  task automatic test_range();
    send_test(32'd5, 32'd1);
    send_test(32'd5, 32'd0);
    send_test(32'd5, 32'd4);
    send_test(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_test(32'd7, 32'hFFFF_FFFF);
  endtask

  task automatic test_known();
    send_test(32'd5, 32'd2);
    send_test(32'd5, 32'd3);
    send_test(32'd561, 32'd2);          // Carmichael number
    send_test(32'd221, 32'd174);        // strong liar
    send_test(32'd221, 32'd137);
    send_test(32'd65537, 32'd3);
    send_test(32'hFFFF_FFFB, 32'd2);    // largest 32-bit prime
    send_test(32'hFFFF_FFFF, 32'hFFFF_FFFD);
    send_test(32'hFFFF_FFFB, 32'hFFFF_FFF9);
    send_test(32'd97, 32'd96);          // n-1 witness is out of range
    send_test(32'd2047, 32'd2);         // base-2 pseudoprime
  endtask

  task automatic test_random(int unsigned count);
    logic [31:0] n;
    for (int unsigned k = 0; k < count; k++) begin
      case ($urandom_range(9))
        0:       send_test($urandom(), $urandom());
        1:       send_test($urandom() & ~32'd1, $urandom());
        2: begin
          n = rand_odd(5, 32'hFFFF_FFFF);
          send_test(n, ($urandom_range(1) != 0) ? $urandom_range(1) : n - 32'd1);
        end
        3, 4: begin
          n = rand_odd(5, 1000);
          send_test(n, rand_witness(n));
        end
        default: begin
          n = rand_odd(5, 32'hFFFF_FFFF);
          send_test(n, rand_witness(n));
        end
      endcase
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      result_cnt++;
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("unexpected verdict %0d", verdict_o));
      end else begin
        if (verdict_o !== verdict_q[0]) begin
          report_mismatch($sformatf("verdict %0d, want %0d", verdict_o, verdict_q[0]));
        end
        void'(verdict_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LimitCycles) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    start       = 1'b0;
    candidate_i = '0;
    witness_i   = '0;
    rst_ni      = 1'b0;
    err_cnt     = 0;
    beat_cnt    = 0;
    result_cnt  = 0;
    cycle_cnt   = 0;
    idle_pct    = 15;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_trivial();
    test_range();
    test_known();
    // hold off until everything has drained
    wait_drained();
    idle_pct = 52;
    test_random(35);
    idle_pct = 0;
    test_random(40);
    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("Covered trivial, small-prime, out-of-range and full witness rounds.");
    $display("%0d beats sent, %0d verdicts checked", beat_cnt, result_cnt);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
